[rtl/psc_pkg.sv]
package psc_pkg;

  localparam int ALPHA_SIZE = 26;
  localparam logic [7:0] LETTER_A = 8'd97;
  localparam logic [4:0] SHIFT_RESET = 5'd0;
  localparam logic [4:0] ARITH_STEP_RESET = 5'd3;
  localparam logic [4:0] GEO_RATIO_RESET = 5'd2;
  localparam logic [4:0] OFFSET_START = 5'd1;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SHIFT = 2'd0,
    REG_MODE  = 2'd1,
    REG_STEP  = 2'd2,
    REG_RATIO = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_ARITH = 2'd0,
    MODE_GEO   = 2'd1,
    MODE_FIB   = 2'd2,
    MODE_PASS  = 2'd3
  } seq_mode_t;

  // Reduce a value below 1024 mod 26: reciprocal estimate, then one correction.
  function automatic logic [4:0] mod26(input logic [9:0] v);
    logic [17:0] prod;
    logic [5:0]  q;
    logic [10:0] qm;
    logic [5:0]  r;
    prod = v * 8'd157;
    q    = prod[17:12];
    qm   = q * 5'd26;
    r    = 6'(v - qm[9:0]);
    if (r >= 6'd26) begin
      r = r - 6'd26;
    end
    return r[4:0];
  endfunction

  // Add two residues and fold back into 0..25.
  function automatic logic [4:0] add26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'd26) begin
      s = s - 6'd26;
    end
    return s[4:0];
  endfunction

endpackage

[rtl/psc_if.sv]
interface psc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       word_end;

  modport source (output valid, output plain_byte, output word_end, input ready);
  modport sink   (input valid, input plain_byte, input word_end, output ready);
endinterface

interface psc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       word_end_out;

  modport source (output valid, output cipher_byte, output word_end_out, input ready);
  modport sink   (input valid, input cipher_byte, input word_end_out, output ready);
endinterface

interface psc_cfg_if import psc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

[rtl/progressive_shift_letter_cipher.sv]
// Progressive shift letter cipher.
// din carries one character (plain_byte) and a last-of-word flag (word_end);
// dout returns one item per input item: cipher_byte and word_end_out.
// cfg writes registers by addr: 0 shift amount, 1 sequence mode
// (arithmetic, geometric, Fibonacci, pass-through), 2 arithmetic step,
// 3 geometric ratio. Values 26..31 for 0, 2 and 3 are folded mod 26.
// cfg.ready is always high; write only while no item is in flight.
// An accepted item is captured in the output register and shown on dout,
// held until taken. One item per cycle while dout.ready holds; the only
// storage in the path is the single output register.
// din.ready is high whenever the output register is empty or being taken
// this cycle, so a stalled receiver stalls din after one buffered item.
// The offset (outside pass-through) and the Fibonacci term (Fibonacci mode)
// update per accepted item and return to 1 after an item with word_end set.
// Reset (rst, synchronous): registers to their defaults (shift 0, arithmetic
// mode, step 3, ratio 2), offsets to 1, output empty.
module progressive_shift_letter_cipher
  import psc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  psc_in_if.sink   din,
  psc_out_if.source dout,
  psc_cfg_if.sink  cfg
);

  logic [4:0] shift_amount;
  seq_mode_t  sequence_mode;
  logic [4:0] arith_step;
  logic [4:0] geo_ratio;

  logic [4:0] offset_now;
  logic [4:0] offset_now_next;
  logic [4:0] fib_next;
  logic [4:0] fib_next_next;

  logic       out_valid;
  logic [7:0] cipher_byte;
  logic       word_end_out;
  logic [7:0] cipher_byte_next;

  logic       in_take;
  logic [4:0] byte_res;
  logic [6:0] total;
  logic [6:0] letter_res;
  logic [4:0] cfg_res;

  assign cfg.ready = 1'b1;
  assign cfg_res   = (cfg.data >= 5'd26) ? 5'(cfg.data - 5'd26) : cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_amount  <= SHIFT_RESET;
      sequence_mode <= MODE_ARITH;
      arith_step    <= ARITH_STEP_RESET;
      geo_ratio     <= GEO_RATIO_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.addr))
        REG_SHIFT: shift_amount  <= cfg_res;
        REG_MODE:  sequence_mode <= seq_mode_t'(cfg.data[1:0]);
        REG_STEP:  arith_step    <= cfg_res;
        REG_RATIO: geo_ratio     <= cfg_res;
        default:   shift_amount  <= shift_amount;
      endcase
    end
  end

  assign din.ready = !out_valid || dout.ready;
  assign in_take   = din.valid && din.ready;

  always_comb begin
    byte_res = mod26({2'b00, din.plain_byte});
    total    = 7'(byte_res) + 7'd7 + 7'(shift_amount) + 7'(offset_now);
    if (total >= 7'd78) begin
      letter_res = total - 7'd78;
    end else if (total >= 7'd52) begin
      letter_res = total - 7'd52;
    end else if (total >= 7'd26) begin
      letter_res = total - 7'd26;
    end else begin
      letter_res = total;
    end

    cipher_byte_next = LETTER_A + 8'(letter_res);
    offset_now_next  = offset_now;
    fib_next_next    = fib_next;
    case (sequence_mode)
      MODE_ARITH: begin
        offset_now_next = add26(offset_now, arith_step);
      end
      MODE_GEO: begin
        offset_now_next = mod26({5'b00000, offset_now} * {5'b00000, geo_ratio});
      end
      MODE_FIB: begin
        offset_now_next = fib_next;
        fib_next_next   = add26(offset_now, fib_next);
      end
      MODE_PASS: begin
        cipher_byte_next = din.plain_byte;
      end
      default: begin
        cipher_byte_next = din.plain_byte;
      end
    endcase

    if (din.word_end) begin
      offset_now_next = OFFSET_START;
      fib_next_next   = OFFSET_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_now <= OFFSET_START;
      fib_next   <= OFFSET_START;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        offset_now <= offset_now_next;
        fib_next   <= fib_next_next;
        out_valid  <= 1'b1;
      end else if (dout.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cipher_byte  <= cipher_byte_next;
      word_end_out <= din.word_end;
    end
  end

  assign dout.valid        = out_valid;
  assign dout.cipher_byte  = cipher_byte;
  assign dout.word_end_out = word_end_out;

endmodule

[rtl/psc_checker.sv]
module psc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_word_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_cipher_byte,
  input logic       out_word_end
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_take_gives_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item did not reach output");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output register");

  a_flag_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_word_end == $past(in_word_end))
    else $error("word end flag not carried");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_cipher_byte))
    else $error("stalled output changed");

endmodule

bind progressive_shift_letter_cipher psc_checker u_psc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (din.valid),
  .in_ready        (din.ready),
  .in_word_end     (din.word_end),
  .out_valid       (dout.valid),
  .out_ready       (dout.ready),
  .out_cipher_byte (dout.cipher_byte),
  .out_word_end    (dout.word_end_out)
);
